>>> sv/srg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srg_pkg;

    // Field widths
    localparam int VALUE_W = 30;
    localparam int SEED_W  = 31;
    localparam int IDX_W   = 6;

    // Table geometry
    localparam logic [IDX_W-1:0] TABLE_LEN   = 6'd55;
    localparam logic [IDX_W-1:0] TABLE_LAST  = 6'd54;
    localparam logic [IDX_W-1:0] FILL_STEP   = 6'd21;
    localparam logic [IDX_W-1:0] LAG_START   = 6'd31;
    localparam logic [IDX_W-1:0] WARM_OFFSET = 6'd31;

    // Arithmetic constants
    localparam logic [SEED_W-1:0] SEED_BASE = 31'd161803398;
    localparam logic [SEED_W-1:0] MOD_BIG   = 31'd1000000000;

    // Default number of warm-up passes over the table
    localparam int WARMUP_ROUNDS_DEF = 4;

    // Operation codes
    localparam logic OP_DRAW   = 1'b0;
    localparam logic OP_RESEED = 1'b1;

endpackage

`default_nettype wire

>>> sv/srg_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface srg_req_if;
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic [srg_pkg::SEED_W-1:0]   seed;

    modport source (output valid, output op, output seed, input ready);
    modport sink   (input valid, input op, input seed, output ready);
endinterface

`default_nettype wire

>>> sv/srg_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface srg_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [srg_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

>>> sv/srg_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Generic RAM: one write port, two registered read ports
module srg_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 55,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr0,
    input  wire logic [AW-1:0]    raddr1,
    output logic      [WIDTH-1:0] rdata0,
    output logic      [WIDTH-1:0] rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

`default_nettype wire

>>> sv/subtractive_random_generator_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Draw: accepted in ST_IDLE, result registered by ST_DRAW_WR, which stalls while
//   an earlier result is unaccepted; one draw at a time on the single table RAM.
// Reseed (or first transaction after reset): a seed write, 54 fill writes, then
//   WARMUP_ROUNDS passes of 55 warm-up updates (read state, write state).
// Reset clears state, read index and seeded flag and sets the lag index to 31; the
//   table is undefined until the first transaction fills it, which always happens.
module subtractive_random_generator_core #(
    parameter int WARMUP_ROUNDS = srg_pkg::WARMUP_ROUNDS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    srg_req_if.sink    req,
    srg_rsp_if.source  rsp
);

    localparam int RW = (WARMUP_ROUNDS > 1) ? $clog2(WARMUP_ROUNDS) : 1;
    localparam logic [RW-1:0] LAST_ROUND = RW'(WARMUP_ROUNDS - 1);
    localparam int VW = srg_pkg::VALUE_W;
    localparam int SW = srg_pkg::SEED_W;
    localparam int IW = srg_pkg::IDX_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_FILL,
        ST_WARM_RD,
        ST_WARM_WR,
        ST_DRAW_RD,
        ST_DRAW_WR
    } state_t;

    state_t          state_reg, state_next;
    logic            seeded_reg, seeded_next;
    logic [IW-1:0]   read_idx_reg, read_idx_next;
    logic [IW-1:0]   lag_idx_reg, lag_idx_next;
    logic [SW-1:0]   seed_reg, seed_next;
    logic [VW-1:0]   mj_reg, mj_next;
    logic [VW-1:0]   mk_reg, mk_next;
    logic [IW-1:0]   pos_reg, pos_next;
    logic [IW-1:0]   cnt_reg, cnt_next;
    logic [IW-1:0]   wi_reg, wi_next;
    logic [IW-1:0]   wj_reg, wj_next;
    logic [RW-1:0]   round_reg, round_next;
    logic            out_valid_reg, out_valid_next;
    logic [VW-1:0]   out_value_reg, out_value_next;

    // RAM ports
    logic            ram_we;
    logic [IW-1:0]   ram_waddr;
    logic [VW-1:0]   ram_wdata;
    logic [IW-1:0]   ram_raddr0;
    logic [IW-1:0]   ram_raddr1;
    logic [VW-1:0]   ram_rdata0;
    logic [VW-1:0]   ram_rdata1;

    // Shared wrap-around subtractor
    logic [VW-1:0]   sub_a;
    logic [VW-1:0]   sub_b;
    logic [VW-1:0]   sub_res;

    logic [SW-1:0]   seed_absdiff;
    logic [VW-1:0]   seed_mod;
    logic [IW:0]     pos_sum;
    logic [IW-1:0]   read_addr;
    logic [IW-1:0]   lag_addr;
    logic            req_fire;
    logic            rsp_fire;

    srg_ram #(
        .WIDTH (VW),
        .DEPTH (int'(srg_pkg::TABLE_LEN)),
        .AW    (IW)
    ) u_table (
        .clk    (clk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .raddr0 (ram_raddr0),
        .raddr1 (ram_raddr1),
        .rdata0 (ram_rdata0),
        .rdata1 (ram_rdata1)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.value = out_value_reg;
    assign rsp_fire  = out_valid_reg && rsp.ready;

    // |seed - base| at accept time
    assign seed_absdiff = (req.seed >= srg_pkg::SEED_BASE) ?
                          (req.seed - srg_pkg::SEED_BASE) :
                          (srg_pkg::SEED_BASE - req.seed);

    // Difference stays below twice the modulus: one compare and subtract
    assign seed_mod = (seed_reg >= srg_pkg::MOD_BIG) ?
                      VW'(seed_reg - srg_pkg::MOD_BIG) : seed_reg[VW-1:0];

    // Address of the advanced index (55 wraps to entry 1, address 0)
    assign read_addr = (read_idx_reg == srg_pkg::TABLE_LEN) ? '0 : read_idx_reg;
    assign lag_addr  = (lag_idx_reg == srg_pkg::TABLE_LEN) ? '0 : lag_idx_reg;

    // Fill position steps by 21 modulo 55
    assign pos_sum = {1'b0, pos_reg} + {1'b0, srg_pkg::FILL_STEP};

    // Operand select for the shared subtractor
    always_comb
    begin
        if (state_reg == ST_FILL)
        begin
            sub_a = mj_reg;
            sub_b = mk_reg;
        end
        else
        begin
            sub_a = ram_rdata0;
            sub_b = ram_rdata1;
        end
    end

    assign sub_res = (sub_a >= sub_b) ? (sub_a - sub_b) :
                     VW'({1'b0, sub_a} + srg_pkg::MOD_BIG - {1'b0, sub_b});

    // Read addresses: warm-up pair or the next draw pair
    always_comb
    begin
        if (state_reg == ST_WARM_RD || state_reg == ST_WARM_WR)
        begin
            ram_raddr0 = wi_reg;
            ram_raddr1 = wj_reg;
        end
        else
        begin
            ram_raddr0 = read_addr;
            ram_raddr1 = lag_addr;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        seeded_next    = seeded_reg;
        read_idx_next  = read_idx_reg;
        lag_idx_next   = lag_idx_reg;
        seed_next      = seed_reg;
        mj_next        = mj_reg;
        mk_next        = mk_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        wi_next        = wi_reg;
        wj_next        = wj_reg;
        round_next     = round_reg;
        out_valid_next = out_valid_reg && !rsp_fire;
        out_value_next = out_value_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = sub_res;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    seed_next = seed_absdiff;
                    if (req.op == srg_pkg::OP_RESEED || !seeded_reg)
                    begin
                        state_next = ST_SEED;
                    end
                    else
                    begin
                        state_next = ST_DRAW_WR;
                    end
                end
            end

            // Last entry takes the reduced seed difference
            ST_SEED:
            begin
                ram_we        = 1'b1;
                ram_waddr     = srg_pkg::TABLE_LAST;
                ram_wdata     = seed_mod;
                mj_next       = seed_mod;
                mk_next       = VW'(1);
                pos_next      = srg_pkg::FILL_STEP;
                cnt_next      = IW'(1);
                read_idx_next = '0;
                lag_idx_next  = srg_pkg::LAG_START;
                state_next    = ST_FILL;
            end

            // Spread the seed chain over the table in 21-step order
            ST_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg - IW'(1);
                ram_wdata = mk_reg;
                mk_next   = sub_res;
                mj_next   = mk_reg;
                pos_next  = (pos_sum >= {1'b0, srg_pkg::TABLE_LEN}) ?
                            IW'(pos_sum - {1'b0, srg_pkg::TABLE_LEN}) : pos_sum[IW-1:0];
                if (cnt_reg == srg_pkg::TABLE_LAST)
                begin
                    wi_next    = '0;
                    wj_next    = srg_pkg::WARM_OFFSET;
                    round_next = '0;
                    state_next = ST_WARM_RD;
                end
                else
                begin
                    cnt_next = cnt_reg + IW'(1);
                end
            end

            ST_WARM_RD:
            begin
                state_next = ST_WARM_WR;
            end

            // entry[i] -= entry[(i+31) mod 55]
            ST_WARM_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = wi_reg;
                wj_next   = (wj_reg == srg_pkg::TABLE_LAST) ? '0 : wj_reg + IW'(1);
                if (wi_reg == srg_pkg::TABLE_LAST)
                begin
                    wi_next = '0;
                    if (round_reg == LAST_ROUND)
                    begin
                        seeded_next = 1'b1;
                        state_next  = ST_DRAW_RD;
                    end
                    else
                    begin
                        round_next = round_reg + RW'(1);
                        state_next = ST_WARM_RD;
                    end
                end
                else
                begin
                    wi_next    = wi_reg + IW'(1);
                    state_next = ST_WARM_RD;
                end
            end

            ST_DRAW_RD:
            begin
                state_next = ST_DRAW_WR;
            end

            // Lagged subtraction, write back, present result
            ST_DRAW_WR:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    ram_we         = 1'b1;
                    ram_waddr      = read_addr;
                    out_valid_next = 1'b1;
                    out_value_next = sub_res;
                    read_idx_next  = read_addr + IW'(1);
                    lag_idx_next   = lag_addr + IW'(1);
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seeded_reg    <= 1'b0;
            read_idx_reg  <= '0;
            lag_idx_reg   <= srg_pkg::LAG_START;
            seed_reg      <= '0;
            mj_reg        <= '0;
            mk_reg        <= '0;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            wi_reg        <= '0;
            wj_reg        <= '0;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            seeded_reg    <= seeded_next;
            read_idx_reg  <= read_idx_next;
            lag_idx_reg   <= lag_idx_next;
            seed_reg      <= seed_next;
            mj_reg        <= mj_next;
            mk_reg        <= mk_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            wi_reg        <= wi_next;
            wj_reg        <= wj_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
            out_value_reg <= out_value_next;
        end
    end

endmodule

`default_nettype wire
